// ===== hw/rtl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared widths and defaults for the signed square root unit.
// ----------------------------------------------------------------------------
package ssr_pkg;

    // result field: signed Q8.16 root, 25 bits
    localparam int OUT_WIDTH      = 25;
    localparam int OUT_TDATA_W    = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int OUT_MAG_W      = OUT_WIDTH - 1;

    // parameter defaults
    localparam int IN_WIDTH_DEF   = 32;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

// ===== hw/rtl/ssr_cell.sv =====
// ----------------------------------------------------------------------------
// ssr_cell
// One digit step of the restoring square root: takes the next radicand bit
// pair, tries the subtraction and hands the partial root on to its neighbor.
// ----------------------------------------------------------------------------
module ssr_cell #(
    parameter int RAD_W  = 48,
    parameter int ROOT_W = 24,
    parameter int REM_W  = 26
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [ROOT_W-1:0] in_root,
    input  logic              in_neg,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [RAD_W-1:0]  out_rad,
    output logic [REM_W-1:0]  out_rem,
    output logic [ROOT_W-1:0] out_root,
    output logic              out_neg
);

    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              neg_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb begin
        // top two bits of the previous remainder are always zero
        rem_sh    = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
        trial     = {in_root, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[ROOT_W-2:0], take};
        rad_next  = in_rad << 2;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            neg_reg  <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_neg   = neg_reg;

endmodule

// ===== hw/rtl/signed_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// signed_square_root_unit
// Sign-preserving square root of one fixed-point pixel per transaction.
// ----------------------------------------------------------------------------
// Each pixel (signed, FRAC_BITS fraction bits, low IN_WIDTH bits of tdata
// used) gives root = floor(sqrt(|x| << FRAC_BITS)) with the sign of x put
// back, saturated to 24 magnitude bits. The root is formed by a row of
// (IN_WIDTH + FRAC_BITS + 1) / 2 cells, one radicand bit pair each, followed
// by an output register. A new pixel is taken every cycle unless the
// first cell is full and stalled; each cell holds its data only while the
// stage after it is full and stalled, so a stalled result still lets
// earlier stages fill.
// ----------------------------------------------------------------------------
module signed_square_root_unit #(
    parameter int IN_WIDTH  = ssr_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [IN_WIDTH-1:0] pixel_value
    input  logic [((IN_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [24:0] root_value
    output logic [ssr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import ssr_pkg::*;

    localparam int RAD_BITS = IN_WIDTH + FRAC_BITS;
    localparam int PAIRS    = (RAD_BITS + 1) / 2;
    localparam int RAD_W    = 2 * PAIRS;
    localparam int ROOT_W   = PAIRS;
    localparam int REM_W    = PAIRS + 2;
    localparam int WIDE_W   = (ROOT_W > OUT_WIDTH) ? ROOT_W : OUT_WIDTH;
    localparam logic [WIDE_W-1:0] MAG_MAX = WIDE_W'((64'd1 << OUT_MAG_W) - 64'd1);

    // chain links, index 0 feeds the first cell
    logic              lnk_valid [0:PAIRS];
    logic              lnk_ready [0:PAIRS];
    logic [RAD_W-1:0]  lnk_rad   [0:PAIRS];
    logic [REM_W-1:0]  lnk_rem   [0:PAIRS];
    logic [ROOT_W-1:0] lnk_root  [0:PAIRS];
    logic              lnk_neg   [0:PAIRS];

    logic [IN_WIDTH-1:0] raw;
    logic [IN_WIDTH-1:0] mag;

    // most negative input negates onto itself, which is its exact magnitude
    always_comb begin
        raw = s_axis_tdata[IN_WIDTH-1:0];
        mag = raw[IN_WIDTH-1] ? (~raw + IN_WIDTH'(1)) : raw;
    end

    assign lnk_valid[0]  = s_axis_tvalid;
    assign s_axis_tready = lnk_ready[0];
    assign lnk_rad[0]    = RAD_W'(mag) << FRAC_BITS;
    assign lnk_rem[0]    = '0;
    assign lnk_root[0]   = '0;
    assign lnk_neg[0]    = raw[IN_WIDTH-1];

    for (genvar i = 0; i < PAIRS; i++) begin : g_cell
        ssr_cell #(
            .RAD_W  (RAD_W),
            .ROOT_W (ROOT_W),
            .REM_W  (REM_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lnk_valid[i]),
            .in_ready  (lnk_ready[i]),
            .in_rad    (lnk_rad[i]),
            .in_rem    (lnk_rem[i]),
            .in_root   (lnk_root[i]),
            .in_neg    (lnk_neg[i]),
            .out_valid (lnk_valid[i+1]),
            .out_ready (lnk_ready[i+1]),
            .out_rad   (lnk_rad[i+1]),
            .out_rem   (lnk_rem[i+1]),
            .out_root  (lnk_root[i+1]),
            .out_neg   (lnk_neg[i+1])
        );
    end

    // output stage: saturate, put the sign back
    logic                 m_valid_reg;
    logic [OUT_WIDTH-1:0] root_reg, root_next;
    logic [WIDE_W-1:0]    root_wide;
    logic [OUT_WIDTH-1:0] root_mag;
    logic                 out_load;

    always_comb begin
        root_wide = WIDE_W'(lnk_root[PAIRS]);
        root_mag  = (root_wide > MAG_MAX) ? OUT_WIDTH'(MAG_MAX)
                                          : root_wide[OUT_WIDTH-1:0];
        root_next = lnk_neg[PAIRS] ? (~root_mag + OUT_WIDTH'(1)) : root_mag;
    end

    assign out_load         = !m_valid_reg || m_axis_tready;
    assign lnk_ready[PAIRS] = out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= lnk_valid[PAIRS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && lnk_valid[PAIRS]) begin
            root_reg <= root_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(root_reg);

endmodule

// ===== tb/sv/tb_signed_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// tb_signed_square_root_unit
// Self-checking bench for the sign-preserving fixed-point square root unit.
// ----------------------------------------------------------------------------
// Pixels go in on the slave stream. Every accepted transaction pushes its
// expected signed root into a queue. The root is either typed into the
// directed table or computed by a digit-by-digit integer square root.
// Each accepted master-side transaction is compared with the oldest entry.
// The random part runs in three idling phases. At the start of the last
// phase the receiver holds off for a long stretch, so the pipeline fills up.
// ----------------------------------------------------------------------------
module tb_signed_square_root_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W        = ssr_pkg::IN_WIDTH_DEF;
    localparam int FRAC_W       = ssr_pkg::FRAC_BITS_DEF;
    localparam int ROOT_W       = ssr_pkg::OUT_WIDTH;
    localparam int RAD_PAIRS    = (PIX_W + FRAC_W + 1) / 2;
    localparam int ITEMS_PER_PH = 620;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              known;
        logic [ROOT_W-1:0] root;
    } pixel_row_t;

    localparam int N_ROWS = 17;
    localparam pixel_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{32'h0000_0000, 1'b1, 25'h000_0000},  // zero
        '{32'h0001_0000, 1'b1, 25'h001_0000},  // 1.0 -> 1.0
        '{32'hFFFF_0000, 1'b1, 25'h1FF_0000},  // -1.0 -> -1.0
        '{32'h0004_0000, 1'b1, 25'h002_0000},  // 4.0 -> 2.0
        '{32'h0000_0001, 1'b1, 25'h000_0100},  // one lsb -> 1/256
        '{32'hFFFF_FFFF, 1'b1, 25'h1FF_FF00},  // minus one lsb
        '{32'h7FFF_FFFF, 1'b0, 25'h0},         // largest positive
        '{32'h8000_0000, 1'b0, 25'h0},         // most negative, exact magnitude
        '{32'h8000_0001, 1'b0, 25'h0},
        '{32'h0000_0002, 1'b0, 25'h0},
        '{32'h0000_0003, 1'b0, 25'h0},
        '{32'h0000_8000, 1'b0, 25'h0},
        '{32'h5555_5555, 1'b0, 25'h0},
        '{32'hAAAA_AAAA, 1'b0, 25'h0},
        '{32'hFFFF_8000, 1'b0, 25'h0},
        '{32'h00C8_0000, 1'b0, 25'h0},
        '{32'h0002_0000, 1'b0, 25'h0}
    };

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [PIX_W-1:0]                s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ssr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    logic [ROOT_W-1:0] expected_roots [$];
    int                mismatch_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              hold_req = 1'b0;
    logic              hold_done = 1'b0;

    signed_square_root_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // floor(sqrt(|x| << FRAC_W)) one bit pair at a time, sign put back
    function automatic logic [ROOT_W-1:0] signed_root(input logic [PIX_W-1:0] pix);
        logic                    neg;
        logic [PIX_W-1:0]        mag;
        logic [PIX_W+FRAC_W-1:0] rad;
        logic [63:0]             rem;
        logic [63:0]             root;
        logic [63:0]             trial;
        logic [ROOT_W-1:0]       res;
        neg = pix[PIX_W-1];
        mag = neg ? (~pix + 1'b1) : pix;
        rad = {mag, {FRAC_W{1'b0}}};
        rem = '0;
        root = '0;
        for (int p = RAD_PAIRS - 1; p >= 0; p--) begin
            rem = (rem << 2) | 64'(rad[2*p+1 -: 2]);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        if (root > 64'((1 << (ROOT_W - 1)) - 1))
            root = 64'((1 << (ROOT_W - 1)) - 1);
        res = root[ROOT_W-1:0];
        return neg ? (~res + 1'b1) : res;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] v;
        int unsigned      k;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(0, 511);
            2: begin
                // exact squares and their neighbors
                k = $urandom_range(0, 46340);
                v = k * k + $urandom_range(0, 2) - 1;
            end
            3: v = 32'h7FFF_FFFF - $urandom_range(0, 15);
            4: v = 32'h0001_0000 + $urandom_range(0, 255) - 128;
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(1))
            v = ~v + 1'b1;
        return v;
    endfunction

    task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic known,
                               input logic [ROOT_W-1:0] root);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge aclk); while (!s_axis_tready);
        expected_roots.push_back(known ? root : signed_root(pix));
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_roots.size() == 0) begin
                $display("%0t: root_value unexpected transaction, actual %h",
                         $time, m_axis_tdata[ROOT_W-1:0]);
                mismatch_count++;
            end else begin
                if (m_axis_tdata[ROOT_W-1:0] !== expected_roots[0]) begin
                    $display("%0t: root_value expected %h, actual %h",
                             $time, expected_roots[0], m_axis_tdata[ROOT_W-1:0]);
                    mismatch_count++;
                end
                void'(expected_roots.pop_front());
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 34;
        recv_idle_pct = 46;
        for (int i = 0; i < N_ROWS; i++)
            offer_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].known,
                        DIRECTED_ROWS[i].root);
        for (int i = 0; i < ITEMS_PER_PH; i++)
            offer_pixel(random_pixel(), 1'b0, '0);

        send_idle_pct = 46;
        recv_idle_pct = 34;
        for (int i = 0; i < ITEMS_PER_PH; i++)
            offer_pixel(random_pixel(), 1'b0, '0);

        // no idling, receiver holds off first so the pipeline backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < ITEMS_PER_PH; i++)
            offer_pixel(random_pixel(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (expected_roots.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
